[rtl/lateral_edge_binning_unit_defines.svh]
// Assertion helpers shared by the checker.
`ifndef LATERAL_EDGE_BINNING_UNIT_DEFINES_SVH
`define LATERAL_EDGE_BINNING_UNIT_DEFINES_SVH

// Same-cycle implication, masked during reset
`define LEBU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lebu check failed");

// Next-cycle implication, masked during reset
`define LEBU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lebu check failed");

// Next-cycle implication that also holds across reset
`define LEBU_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lebu check failed");

`endif

[rtl/lebu_pkg.sv]
package lebu_pkg;

  localparam int MAX_BINS = 64;
  localparam int NSLOTS   = 2 * MAX_BINS;
  localparam int SLOT_W   = $clog2(NSLOTS);
  localparam int CFG_W    = 17;
  localparam int BPS_W    = 7;
  localparam int COORD_W  = 18;
  localparam int CENTRE_W = 24;
  localparam int NUM_W    = 19;
  localparam int DEN_W    = 18;
  localparam int CNT_W    = $clog2(NUM_W + 1);

  // Input item kinds
  localparam logic [1:0] KIND_POINT = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // Register indexes
  localparam logic [1:0] CFG_HALF_LENGTH   = 2'd0;
  localparam logic [1:0] CFG_BIN_WIDTH     = 2'd1;
  localparam logic [1:0] CFG_BINS_PER_SIDE = 2'd2;
  localparam logic [1:0] CFG_EDGE_WIDTH    = 2'd3;

  typedef enum logic [1:0] {OP_POINT, OP_READ, OP_CLEAR} op_t;

  // One queued command from front to back
  typedef struct packed {
    op_t                        op;
    logic signed [COORD_W-1:0]  x;
    logic                       neg;
    logic [NUM_W-1:0]           num;
    logic [SLOT_W-1:0]          bin_index;
  } cmd_t;

  typedef struct packed {
    logic [CFG_W-1:0] half_length;
    logic [CFG_W-1:0] bin_width;
    logic [BPS_W-1:0] bins_per_side;
    logic [CFG_W-1:0] edge_width;
  } cfg_t;

  // Bins per side limited to the storage
  function automatic logic [BPS_W-1:0] eff_bps(input logic [BPS_W-1:0] bps);
    logic [BPS_W-1:0] lim;
    lim = BPS_W'(MAX_BINS);
    return (bps > lim) ? lim : bps;
  endfunction

endpackage

[rtl/lebu_if.sv]
interface lebu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic signed [17:0] x;
  logic signed [17:0] y;
  logic [6:0]  bin_index;
  modport source(output valid, kind, x, y, bin_index, input ready);
  modport sink(input valid, kind, x, y, bin_index, output ready);
endinterface

interface lebu_out_if;
  logic        valid;
  logic        ready;
  logic signed [23:0] bin_centre_y;
  logic signed [17:0] right_x;
  logic signed [17:0] left_x;
  modport source(output valid, bin_centre_y, right_x, left_x, input ready);
  modport sink(input valid, bin_centre_y, right_x, left_x, output ready);
endinterface

[rtl/lebu_front.sv]
module lebu_front (
  lebu_in_if.sink          item_in,
  input  lebu_pkg::cfg_t   cfg,
  input  logic             full,
  output logic             push,
  output lebu_pkg::cmd_t   cmd
);

  logic [lebu_pkg::COORD_W-1:0] ay;
  logic                         keep;

  assign item_in.ready = !full;

  // Magnitude of y, used by the range check
  always_comb begin
    ay = item_in.y[17] ? lebu_pkg::COORD_W'(-item_in.y) : lebu_pkg::COORD_W'(item_in.y);
  end

  // Classify the item; dropped items are still accepted
  always_comb begin
    cmd.x         = item_in.x;
    cmd.neg       = item_in.y[17];
    cmd.num       = {ay, 1'b0} + lebu_pkg::NUM_W'(cfg.bin_width);
    cmd.bin_index = item_in.bin_index;
    cmd.op        = lebu_pkg::OP_POINT;
    keep          = 1'b0;
    unique case (item_in.kind)
      lebu_pkg::KIND_POINT: begin
        cmd.op = lebu_pkg::OP_POINT;
        keep   = (cfg.bins_per_side != '0) && (cfg.bin_width != '0) &&
                 (ay < {1'b0, cfg.half_length});
      end
      lebu_pkg::KIND_READ: begin
        cmd.op = lebu_pkg::OP_READ;
        keep   = 1'b1;
      end
      lebu_pkg::KIND_CLEAR: begin
        cmd.op = lebu_pkg::OP_CLEAR;
        keep   = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign push = item_in.valid && !full && keep;

endmodule

[rtl/lebu_queue.sv]
module lebu_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lebu_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           avail,
  output lebu_pkg::cmd_t head
);

  lebu_pkg::cmd_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full  = (count == 2'd2);
  assign avail = (count != 2'd0);
  assign head  = slots[rd_ptr];

  // Two-entry ring
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

endmodule

[rtl/lebu_div.sv]
module lebu_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [lebu_pkg::NUM_W-1:0]  num,
  input  logic [lebu_pkg::DEN_W-1:0]  den,
  output logic                        done,
  output logic [lebu_pkg::NUM_W-1:0]  quo
);

  logic                        busy;
  logic [lebu_pkg::CNT_W-1:0]  cnt;
  logic [lebu_pkg::DEN_W-1:0]  rem;
  logic [lebu_pkg::DEN_W-1:0]  dsr;
  logic [lebu_pkg::DEN_W:0]    trial;
  logic                        fits;

  assign done  = busy && (cnt == '0);
  assign trial = {rem, quo[lebu_pkg::NUM_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  // Restoring divide, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= lebu_pkg::CNT_W'(lebu_pkg::NUM_W);
    end else if (done) begin
      busy <= 1'b0;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
      dsr <= den;
    end else if (busy && (cnt != '0)) begin
      rem <= fits ? lebu_pkg::DEN_W'(trial - {1'b0, dsr}) : trial[lebu_pkg::DEN_W-1:0];
      quo <= {quo[lebu_pkg::NUM_W-2:0], fits};
    end
  end

endmodule

[rtl/lebu_back.sv]
module lebu_back (
  input  logic           clk,
  input  logic           rst,
  input  lebu_pkg::cfg_t cfg,
  input  logic           avail,
  input  lebu_pkg::cmd_t head,
  output logic           pop,
  lebu_out_if.source     item_out
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_LOOK  = 3'd2;
  localparam logic [2:0] ST_UPD   = 3'd3;
  localparam logic [2:0] ST_RLOOK = 3'd4;
  localparam logic [2:0] ST_RFIN  = 3'd5;

  localparam int SW = lebu_pkg::SLOT_W;
  localparam int CW = lebu_pkg::COORD_W;

  logic [2:0]             state;
  logic [2:0]             state_next;
  lebu_pkg::cmd_t         cur;
  logic [SW-1:0]          slot;
  logic [SW-1:0]          slot_next;
  logic [SW-1:0]          mem_addr;
  logic [lebu_pkg::NSLOTS-1:0] bin_valid;
  logic signed [CW-1:0]   right_mem [lebu_pkg::NSLOTS];
  logic signed [CW-1:0]   left_mem  [lebu_pkg::NSLOTS];
  logic signed [CW-1:0]   rd_right;
  logic signed [CW-1:0]   rd_left;
  logic signed [CW-1:0]   old_right;
  logic signed [CW-1:0]   old_left;
  logic signed [CW-1:0]   new_right;
  logic signed [CW-1:0]   new_left;
  logic signed [CW-1:0]   def_right;
  logic signed [CW-1:0]   def_left;
  logic                   mem_we;
  logic                   hit;
  logic signed [25:0]     prod;
  logic signed [7:0]      diff;
  logic [lebu_pkg::BPS_W-1:0] bps;
  logic [lebu_pkg::BPS_W:0]   nb;
  logic                   div_start;
  logic                   div_done;
  logic [lebu_pkg::NUM_W-1:0] quo;
  logic [7:0]             qsat;
  logic signed [9:0]      idx;
  logic signed [23:0]     centre;

  assign bps       = lebu_pkg::eff_bps(cfg.bins_per_side);
  assign nb        = {bps, 1'b0};
  assign def_right = CW'(cfg.edge_width);
  assign def_left  = -CW'(cfg.edge_width);

  // Accept a command when idle; a read needs the output register free
  assign pop = (state == ST_IDLE) && avail &&
               ((head.op != lebu_pkg::OP_READ) || !item_out.valid);
  assign div_start = pop && (head.op == lebu_pkg::OP_POINT);

  lebu_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (head.num),
    .den   ({cfg.bin_width, 1'b0}),
    .done  (div_done),
    .quo   (quo)
  );

  // Signed bin number, clamped to the active bins
  always_comb begin
    qsat = (quo > lebu_pkg::NUM_W'(127)) ? 8'd127 : quo[7:0];
    idx  = cur.neg ? ($signed({3'b0, bps}) - $signed({2'b0, qsat}))
                   : ($signed({3'b0, bps}) + $signed({2'b0, qsat}));
    if (idx < 0) begin
      slot_next = '0;
    end else if (idx > $signed({1'b0, nb}) - 10'sd1) begin
      slot_next = SW'(nb - 1'b1);
    end else begin
      slot_next = idx[SW-1:0];
    end
  end

  // Edge update
  always_comb begin
    old_right = bin_valid[slot] ? rd_right : def_right;
    old_left  = bin_valid[slot] ? rd_left  : def_left;
    new_right = old_right;
    new_left  = old_left;
    if (cur.x > 0) begin
      if (cur.x < old_right) new_right = cur.x;
    end else begin
      if (cur.x > old_left) new_left = cur.x;
    end
  end

  // Centre saturation
  always_comb begin
    if (prod > 26'sd8388607) begin
      centre = 24'sd8388607;
    end else if (prod < -26'sd8388608) begin
      centre = -24'sd8388608;
    end else begin
      centre = prod[23:0];
    end
  end

  assign mem_we   = (state == ST_UPD);
  assign mem_addr = (state == ST_RLOOK) ? cur.bin_index : slot;
  assign diff     = $signed({1'b0, cur.bin_index}) - $signed({1'b0, bps});

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (pop) begin
          unique case (head.op)
            lebu_pkg::OP_POINT: state_next = ST_DIV;
            lebu_pkg::OP_READ:  state_next = ST_RLOOK;
            default:            state_next = ST_IDLE;
          endcase
        end
      end
      ST_DIV:   if (div_done) state_next = ST_LOOK;
      ST_LOOK:  state_next = ST_UPD;
      ST_UPD:   state_next = ST_IDLE;
      ST_RLOOK: state_next = ST_RFIN;
      ST_RFIN:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Control: state, valid bits, output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      bin_valid      <= '0;
      item_out.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (pop && (head.op == lebu_pkg::OP_CLEAR)) bin_valid <= '0;
      if (mem_we) bin_valid[slot] <= 1'b1;
      if (state == ST_RFIN) begin
        item_out.valid <= 1'b1;
      end else if (item_out.ready) begin
        item_out.valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (pop) cur <= head;
    if ((state == ST_DIV) && div_done) slot <= slot_next;
    if (state == ST_RLOOK) begin
      prod <= diff * $signed({1'b0, cfg.bin_width});
      hit  <= ({1'b0, cur.bin_index} < nb) && bin_valid[cur.bin_index];
    end
    if (state == ST_RFIN) begin
      item_out.bin_centre_y <= centre;
      item_out.right_x      <= hit ? rd_right : def_right;
      item_out.left_x       <= hit ? rd_left  : def_left;
    end
  end

  // Edge memories, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      right_mem[slot] <= new_right;
      left_mem[slot]  <= new_left;
    end
    rd_right <= right_mem[mem_addr];
    rd_left  <= left_mem[mem_addr];
  end

endmodule

[rtl/lateral_edge_binning_unit.sv]
// Lateral edge binning unit. Point items are binned along y (rounded
// y / bin_width, halves away from zero, clamped to the active bins) and
// keep per bin the nearest positive-x point as right edge and the nearest
// non-positive-x point as left edge. Read items return one result (bin
// centre and both edges); clear and point items return none. A two-entry
// command queue sits between input classification and the bin engine, so
// the input keeps taking items while the engine works, until the queue is
// full. Dropped points and unused kinds are accepted too. A point runs
// the 19-step serial divider. Registers must only be written through
// cfg_we/cfg_index/cfg_data while idle; the block does not enforce it.
module lateral_edge_binning_unit (
  input  logic        clk,
  input  logic        rst,
  lebu_in_if.sink     item_in,
  lebu_out_if.source  item_out,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  lebu_pkg::cfg_t cfg;
  lebu_pkg::cmd_t push_cmd;
  lebu_pkg::cmd_t head;
  logic           push;
  logic           pop;
  logic           full;
  logic           avail;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_length   <= 17'd20000;
      cfg.bin_width     <= 17'd500;
      cfg.bins_per_side <= 7'd40;
      cfg.edge_width    <= 17'd3000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lebu_pkg::CFG_HALF_LENGTH:   cfg.half_length   <= cfg_data;
        lebu_pkg::CFG_BIN_WIDTH:     cfg.bin_width     <= cfg_data;
        lebu_pkg::CFG_BINS_PER_SIDE: cfg.bins_per_side <= cfg_data[6:0];
        lebu_pkg::CFG_EDGE_WIDTH:    cfg.edge_width    <= cfg_data;
        default: ;
      endcase
    end
  end

  lebu_front u_front (
    .item_in (item_in),
    .cfg     (cfg),
    .full    (full),
    .push    (push),
    .cmd     (push_cmd)
  );

  lebu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (full),
    .avail    (avail),
    .head     (head)
  );

  lebu_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .avail    (avail),
    .head     (head),
    .pop      (pop),
    .item_out (item_out)
  );

endmodule

[rtl/lebu_checker.sv]
`include "lateral_edge_binning_unit_defines.svh"

module lebu_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_centre,
  input logic [17:0] out_right,
  input logic [17:0] out_left
);

  // Result held while stalled
  `LEBU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `LEBU_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_centre) && $stable(out_right) && $stable(out_left))
  // Right edge never negative, left edge never positive
  `LEBU_ASSERT_NOW(a_edge_sides, out_valid, !out_right[17] && (out_left[17] || (out_left == 18'd0)))
  // No result right after reset
  `LEBU_ASSERT_ALWAYS(a_rst_quiet, rst, !out_valid)

endmodule

bind lateral_edge_binning_unit lebu_checker u_lebu_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (item_out.valid),
  .out_ready  (item_out.ready),
  .out_centre (item_out.bin_centre_y),
  .out_right  (item_out.right_x),
  .out_left   (item_out.left_x)
);
